/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
// every macro samples on aclk and is quiet while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define BSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition that implies a consequence in the next cycle
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bsc_pkg.sv */
// shared types, constants and register indexes of the pressure compensation block
// no dependencies
`timescale 1ns / 1ps

package bsc_pkg;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_AW-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MC_MD   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_OSS     = 3'd5;
    localparam logic [1:0] OSS_RESET = 2'd3;

    // algorithm constants
    localparam logic signed [31:0] C_B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] C_B4_BIAS   = 32'sd32768;
    localparam logic [15:0]        C_B7_SCALE  = 16'd50000;
    localparam logic [11:0]        C_P_K1      = 12'd3038;
    localparam logic signed [13:0] C_P_K2      = -14'sd7357;
    localparam logic signed [31:0] C_P_K3      = 32'sd3791;

    // divider shapes
    localparam int D1_NW = 27;   // |mc * 2048|
    localparam int D1_DW = 18;   // |x1 + md|
    localparam int D2_NW = 32;   // b7 or 2 * b7
    localparam int D2_DW = 17;   // b4

    localparam int C_QUEUE_DEPTH = 4;

    // calibration set as seen by the datapath
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } cfg_t;

    // item handed from front to back
    typedef struct packed {
        logic signed [16:0] x1;
        logic signed [17:0] den;
        logic [23:0]        up;
        logic               fault;
    } q_entry_t;

    // side data through the temperature divider
    typedef struct packed {
        logic signed [16:0] x1;
        logic [23:0]        up;
        logic               neg;
        logic               fault;
    } d1_side_t;

    // side data through the pressure divider
    typedef struct packed {
        logic signed [31:0] t;
        logic               b7_high;
        logic               fault;
    } d2_side_t;

endpackage

/* rtl/bsc_queue.sv */
// short queue between front and back stages
// uses assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         valid
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] wr_ptr_next, rd_ptr_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // pointer wrap
    assign wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_next;
            if (pop)  rd_ptr_reg <= rd_ptr_next;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= din;
    end

    `BSC_ASSERT(a_no_overflow, !(push && full && !pop), "queue push while full")
    `BSC_ASSERT(a_no_underflow, !(pop && !valid), "queue pop while empty")
    `BSC_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost")
endmodule

/* rtl/bsc_front.sv */
// front stage: takes raw samples, starts temperature math, flags a zero divisor
// uses bsc_pkg
`timescale 1ns / 1ps

module bsc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsc_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       raw_temp,
    input  logic [23:0]       raw_press,
    output logic              push,
    input  logic              q_full,
    output bsc_pkg::q_entry_t entry
);
    import bsc_pkg::*;

    logic               f_v_reg;
    logic [31:0]        prod_reg;
    logic [23:0]        up_reg;
    logic signed [16:0] ut_diff;
    logic signed [33:0] prod_next;
    logic [3:0]         up_shift;
    logic [23:0]        up_next;
    logic               f_en;
    logic signed [16:0] x1;
    logic signed [17:0] den;

    // (ut - ac6) * ac5
    assign ut_diff   = $signed({1'b0, raw_temp}) - $signed({1'b0, cfg.ac6});
    assign prod_next = ut_diff * $signed({1'b0, cfg.ac5});
    assign up_shift  = 4'd8 - {2'b00, cfg.oss};
    assign up_next   = raw_press >> up_shift;

    assign f_en     = !f_v_reg || !q_full;
    assign in_ready = f_en;
    assign push     = f_v_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (f_en) begin
            f_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_en && in_valid) begin
            prod_reg <= prod_next[31:0];
            up_reg   <= up_next;
        end
    end

    // x1 and the temperature divisor
    assign x1  = $signed(prod_reg[31:15]);
    assign den = 18'(x1) + 18'(cfg.md);

    assign entry.x1    = x1;
    assign entry.den   = den;
    assign entry.up    = up_reg;
    assign entry.fault = (den == '0);
endmodule

/* rtl/bsc_div_pipe.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
// no dependencies
`timescale 1ns / 1ps

module bsc_div_pipe #(
    parameter int NW = 32,
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] out_side
);
    logic          v_reg   [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] n_reg   [NW];
    logic [NW-1:0] q_reg   [NW];
    logic [DW-1:0] d_reg   [NW];
    logic [SW-1:0] s_reg   [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in, d_in;
        logic [NW-1:0] n_in, q_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   trial, diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign n_in   = num;
            assign q_in   = '0;
            assign d_in   = den;
            assign s_in   = side;
        end else begin : g_rest
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign n_in   = n_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign s_in   = s_reg[k-1];
        end

        // trial subtract
        assign trial = {rem_in, n_in[NW-1]};
        assign ge    = (trial >= {1'b0, d_in});
        assign diff  = trial - {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                n_reg[k]   <= n_in << 1;
                q_reg[k]   <= {q_in[NW-2:0], ge};
                d_reg[k]   <= d_in;
                s_reg[k]   <= s_in;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = q_reg[NW-1];
    assign out_side  = s_reg[NW-1];
endmodule

/* rtl/bsc_back.sv */
// back pipeline: temperature and pressure compensation and result register
// uses bsc_pkg, bsc_div_pipe, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsc_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  bsc_pkg::q_entry_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       temp_tenths,
    output logic [31:0]       press_pa,
    output logic              div_fault
);
    import bsc_pkg::*;

    logic en;
    logic out_v_reg;
    logic [31:0] temp_reg, press_reg;
    logic fault_reg;

    assign en      = !out_v_reg || m_ready;
    assign q_pop   = en && q_valid;
    assign m_valid = out_v_reg;

    // temperature divider: mc * 2048 / (x1 + md)
    logic signed [26:0] d1_num;
    logic [D1_NW-1:0]   d1_num_mag, d1_quo;
    logic [D1_DW-1:0]   d1_den_mag;
    d1_side_t           d1_side, d1_oside;
    logic               d1_ov;

    assign d1_num     = {cfg.mc, 11'd0};
    assign d1_num_mag = cfg.mc[15] ? D1_NW'(-d1_num) : D1_NW'(d1_num);
    assign d1_den_mag = q_head.den[17] ? D1_DW'(-q_head.den) : D1_DW'(q_head.den);
    assign d1_side.x1    = q_head.x1;
    assign d1_side.up    = q_head.up;
    assign d1_side.neg   = cfg.mc[15] ^ q_head.den[17];
    assign d1_side.fault = q_head.fault;

    bsc_div_pipe #(.NW(D1_NW), .DW(D1_DW), .SW($bits(d1_side_t))) u_div_t (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(q_valid), .num(d1_num_mag), .den(d1_den_mag), .side(d1_side),
        .out_valid(d1_ov), .quo(d1_quo), .out_side(d1_oside)
    );

    // stage 1: b5, t, b6
    logic signed [31:0] x2_t, b5, t_next, b6_next;
    logic s1_v_reg;
    logic signed [31:0] s1_t_reg, s1_b6_reg;
    logic [23:0] s1_up_reg;
    logic s1_f_reg;

    assign x2_t    = d1_oside.neg ? -$signed({5'd0, d1_quo}) : $signed({5'd0, d1_quo});
    assign b5      = 32'(d1_oside.x1) + x2_t;
    assign t_next  = (b5 + 32'sd8) >>> 4;
    assign b6_next = b5 - C_B6_OFFSET;

    // stage 2: products of b6
    logic signed [63:0] m_b6sq;
    logic signed [47:0] m_ac2, m_ac3;
    logic s2_v_reg;
    logic [31:0] s2_b6sq_reg, s2_ac2_reg, s2_ac3_reg;
    logic signed [31:0] s2_t_reg;
    logic [23:0] s2_up_reg;
    logic s2_f_reg;

    assign m_b6sq = s1_b6_reg * s1_b6_reg;
    assign m_ac2  = cfg.ac2 * s1_b6_reg;
    assign m_ac3  = cfg.ac3 * s1_b6_reg;

    // stage 3: products of b6 squared
    logic signed [19:0] sq;
    logic signed [35:0] m_b2, m_b1;
    logic s3_v_reg;
    logic [31:0] s3_b2_reg, s3_b1_reg;
    logic signed [20:0] s3_x2a_reg;
    logic signed [18:0] s3_x1c_reg;
    logic signed [31:0] s3_t_reg;
    logic [23:0] s3_up_reg;
    logic s3_f_reg;

    assign sq   = $signed(s2_b6sq_reg[31:12]);
    assign m_b2 = cfg.b2 * sq;
    assign m_b1 = cfg.b1 * sq;

    // stage 4: b3 and the b4 factor
    logic signed [31:0] x3a, v_b3, w_b3, b3_next, x3b, v32_next;
    logic s4_v_reg;
    logic signed [31:0] s4_b3_reg, s4_v32_reg, s4_t_reg;
    logic [23:0] s4_up_reg;
    logic s4_f_reg;

    assign x3a      = 32'($signed(s3_b2_reg[31:11])) + 32'(s3_x2a_reg);
    assign v_b3     = {{14{cfg.ac1[15]}}, cfg.ac1, 2'b00} + x3a;
    assign w_b3     = (v_b3 <<< cfg.oss) + 32'sd2;
    assign b3_next  = (w_b3 + (w_b3[31] ? 32'sd3 : 32'sd0)) >>> 2;
    assign x3b      = (32'(s3_x1c_reg) + 32'($signed(s3_b1_reg[31:16])) + 32'sd2) >>> 2;
    assign v32_next = x3b + C_B4_BIAS;

    // stage 5: b4 product, up - b3
    logic [47:0] m_b4;
    logic s5_v_reg;
    logic [31:0] s5_b4p_reg, s5_diff_reg;
    logic signed [31:0] s5_t_reg;
    logic s5_f_reg;

    assign m_b4 = cfg.ac4 * s4_v32_reg;

    // stage 6: b4, b7
    logic [15:0] b7_scale;
    logic [47:0] m_b7;
    logic s6_v_reg;
    logic [16:0] s6_b4_reg;
    logic [31:0] s6_b7_reg;
    logic signed [31:0] s6_t_reg;
    logic s6_f_reg;

    assign b7_scale = C_B7_SCALE >> cfg.oss;
    assign m_b7     = s5_diff_reg * b7_scale;

    // pressure divider
    logic [D2_NW-1:0] d2_num, d2_quo;
    d2_side_t d2_side, d2_oside;
    logic d2_ov;

    assign d2_num          = s6_b7_reg[31] ? s6_b7_reg : {s6_b7_reg[30:0], 1'b0};
    assign d2_side.t       = s6_t_reg;
    assign d2_side.b7_high = s6_b7_reg[31];
    assign d2_side.fault   = s6_f_reg || (s6_b4_reg == '0);

    bsc_div_pipe #(.NW(D2_NW), .DW(D2_DW), .SW($bits(d2_side_t))) u_div_p (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s6_v_reg), .num(d2_num), .den(s6_b4_reg), .side(d2_side),
        .out_valid(d2_ov), .quo(d2_quo), .out_side(d2_oside)
    );

    // stage 8: first pressure correction products
    logic signed [31:0] p_next;
    logic signed [23:0] p_s8;
    logic signed [47:0] m_psq;
    logic signed [45:0] m_k2;
    logic s8_v_reg;
    logic signed [31:0] s8_p_reg, s8_t_reg;
    logic [31:0] s8_sq_reg, s8_m2_reg;
    logic s8_f_reg;

    assign p_next = d2_oside.b7_high ? $signed({d2_quo[30:0], 1'b0}) : $signed(d2_quo);
    assign p_s8   = p_next[31:8];
    assign m_psq  = p_s8 * p_s8;
    assign m_k2   = C_P_K2 * p_next;

    // stage 9: scale of x1
    logic [43:0] m_k1;
    logic s9_v_reg;
    logic signed [31:0] s9_p_reg, s9_t_reg;
    logic [31:0] s9_k1_reg;
    logic signed [15:0] s9_x2_reg;
    logic s9_f_reg;

    assign m_k1 = s8_sq_reg * C_P_K1;

    // final pressure sum
    logic signed [31:0] adj, press_next;

    assign adj        = (32'($signed(s9_k1_reg[31:16])) + 32'(s9_x2_reg) + C_P_K3) >>> 4;
    assign press_next = s9_p_reg + adj;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg  <= d1_ov;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s8_v_reg  <= d2_ov;
            s9_v_reg  <= s8_v_reg;
            out_v_reg <= s9_v_reg;
        end
    end

    // payload chain
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_t_reg    <= t_next;
            s1_b6_reg   <= b6_next;
            s1_up_reg   <= d1_oside.up;
            s1_f_reg    <= d1_oside.fault;

            s2_b6sq_reg <= m_b6sq[31:0];
            s2_ac2_reg  <= m_ac2[31:0];
            s2_ac3_reg  <= m_ac3[31:0];
            s2_t_reg    <= s1_t_reg;
            s2_up_reg   <= s1_up_reg;
            s2_f_reg    <= s1_f_reg;

            s3_b2_reg   <= m_b2[31:0];
            s3_b1_reg   <= m_b1[31:0];
            s3_x2a_reg  <= $signed(s2_ac2_reg[31:11]);
            s3_x1c_reg  <= $signed(s2_ac3_reg[31:13]);
            s3_t_reg    <= s2_t_reg;
            s3_up_reg   <= s2_up_reg;
            s3_f_reg    <= s2_f_reg;

            s4_b3_reg   <= b3_next;
            s4_v32_reg  <= v32_next;
            s4_t_reg    <= s3_t_reg;
            s4_up_reg   <= s3_up_reg;
            s4_f_reg    <= s3_f_reg;

            s5_b4p_reg  <= m_b4[31:0];
            s5_diff_reg <= {8'd0, s4_up_reg} - s4_b3_reg;
            s5_t_reg    <= s4_t_reg;
            s5_f_reg    <= s4_f_reg;

            s6_b4_reg   <= s5_b4p_reg[31:15];
            s6_b7_reg   <= m_b7[31:0];
            s6_t_reg    <= s5_t_reg;
            s6_f_reg    <= s5_f_reg;

            s8_p_reg    <= p_next;
            s8_sq_reg   <= m_psq[31:0];
            s8_m2_reg   <= m_k2[31:0];
            s8_t_reg    <= d2_oside.t;
            s8_f_reg    <= d2_oside.fault;

            s9_p_reg    <= s8_p_reg;
            s9_k1_reg   <= m_k1[31:0];
            s9_x2_reg   <= $signed(s8_m2_reg[31:16]);
            s9_t_reg    <= s8_t_reg;
            s9_f_reg    <= s8_f_reg;

            // a zero divisor forces both results to zero
            temp_reg    <= s9_f_reg ? '0 : s9_t_reg;
            press_reg   <= s9_f_reg ? '0 : press_next;
            fault_reg   <= s9_f_reg;
        end
    end

    assign temp_tenths = temp_reg;
    assign press_pa    = press_reg;
    assign div_fault   = fault_reg;

    `BSC_ASSERT(a_fault_zero, !(out_v_reg && fault_reg) || (temp_reg == '0 && press_reg == '0), "fault with nonzero result")
    `BSC_ASSERT_NEXT(a_hold_stall, out_v_reg && !m_ready, out_v_reg && $stable(press_reg), "result dropped in stall")
    `BSC_ASSERT(a_pop_only_en, !q_pop || en, "queue popped while back stalled")
endmodule

/* rtl/baro_sensor_compensation.sv */
// throughput: one item per cycle while m_axis is not stalled;
// the two one-bit-per-stage divider pipelines set the depth
// a stalled output holds the whole back pipeline, the queue then absorbs front items
// reset: aresetn synchronous active low, clears valid bits and queue, coefficients to 0
// and oversampling to 3
`timescale 1ns / 1ps

module baro_sensor_compensation #(
    parameter int QUEUE_DEPTH = bsc_pkg::C_QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [bsc_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [31:0]                cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,  // raw_temp[15:0], raw_press[39:16]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,  // temp_tenths[31:0], press_pa[63:32]
    output logic [0:0]                 m_axis_tuser   // div_fault[0]
);
    import bsc_pkg::*;

    logic [31:0] r_ac12_reg, r_ac34_reg, r_ac56_reg, r_b12_reg, r_mcmd_reg;
    logic [1:0]  r_oss_reg;
    cfg_t        cfg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_ac12_reg <= '0;
            r_ac34_reg <= '0;
            r_ac56_reg <= '0;
            r_b12_reg  <= '0;
            r_mcmd_reg <= '0;
            r_oss_reg  <= OSS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_AC1_AC2: r_ac12_reg <= cfg_wdata;
                REG_AC3_AC4: r_ac34_reg <= cfg_wdata;
                REG_AC5_AC6: r_ac56_reg <= cfg_wdata;
                REG_B1_B2:   r_b12_reg  <= cfg_wdata;
                REG_MC_MD:   r_mcmd_reg <= cfg_wdata;
                REG_OSS:     r_oss_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // split coefficients
    assign cfg.ac1 = $signed(r_ac12_reg[31:16]);
    assign cfg.ac2 = $signed(r_ac12_reg[15:0]);
    assign cfg.ac3 = $signed(r_ac34_reg[31:16]);
    assign cfg.ac4 = r_ac34_reg[15:0];
    assign cfg.ac5 = r_ac56_reg[31:16];
    assign cfg.ac6 = r_ac56_reg[15:0];
    assign cfg.b1  = $signed(r_b12_reg[31:16]);
    assign cfg.b2  = $signed(r_b12_reg[15:0]);
    assign cfg.mc  = $signed(r_mcmd_reg[31:16]);
    assign cfg.md  = $signed(r_mcmd_reg[15:0]);
    assign cfg.oss = r_oss_reg;

    logic     push, q_full, q_pop, q_valid;
    q_entry_t f_entry, q_head;
    logic [$bits(q_entry_t)-1:0] q_dout;

    bsc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .raw_temp(s_axis_tdata[15:0]), .raw_press(s_axis_tdata[39:16]),
        .push(push), .q_full(q_full), .entry(f_entry)
    );

    bsc_queue #(.W($bits(q_entry_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .din(f_entry), .full(q_full),
        .pop(q_pop), .dout(q_dout), .valid(q_valid)
    );

    assign q_head = q_dout;

    bsc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .temp_tenths(m_axis_tdata[31:0]), .press_pa(m_axis_tdata[63:32]),
        .div_fault(m_axis_tuser[0])
    );
endmodule
